@@ sv/fpa_pkg.sv @@
// Package with opcodes and the sideband record for the fixed-point ALU pipeline.
`default_nettype none
package fpa_pkg;

    typedef logic [3:0] t_op;

    localparam t_op OP_ADD = 4'd0;
    localparam t_op OP_SUB = 4'd1;
    localparam t_op OP_MUL = 4'd2;
    localparam t_op OP_DIV = 4'd3;
    localparam t_op OP_GT  = 4'd4;
    localparam t_op OP_LT  = 4'd5;
    localparam t_op OP_GE  = 4'd6;
    localparam t_op OP_LE  = 4'd7;
    localparam t_op OP_EQ  = 4'd8;
    localparam t_op OP_NE  = 4'd9;
    localparam t_op OP_MIN = 4'd10;
    localparam t_op OP_MAX = 4'd11;
    localparam t_op OP_INC = 4'd12;
    localparam t_op OP_DEC = 4'd13;
    localparam t_op OP_INT = 4'd14;

    // Data that rides alongside the divider stages.
    typedef struct packed {
        t_op         op;
        logic        neg;
        logic        bzero;
        logic [31:0] res;
        logic        cmp;
        logic        err;
        logic [63:0] prod;
    } t_side;

endpackage
`default_nettype wire

@@ sv/fpa_div_stage.sv @@
// One registered restoring-division step: one quotient bit per stage.
`default_nettype none
module fpa_div_stage #(
    parameter int NW = 40
) (
    input  wire logic          i_clk,
    input  wire logic          i_ld,
    input  wire logic [31:0]   i_rem,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [31:0]   i_den,
    input  wire logic [NW-1:0] i_quo,
    output logic      [31:0]   o_rem,
    output logic      [NW-1:0] o_num,
    output logic      [31:0]   o_den,
    output logic      [NW-1:0] o_quo
);
    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;
    logic [31:0] n_rem;

    // Shift in the next numerator bit and try to subtract the divisor.
    always_comb begin
        trial = {i_rem, i_num[NW-1]};
        diff  = trial - {1'b0, i_den};
        fits  = (trial >= {1'b0, i_den});
        n_rem = fits ? diff[31:0] : trial[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            o_rem <= n_rem;
            o_num <= i_num << 1;
            o_den <= i_den;
            o_quo <= {i_quo[NW-2:0], fits};
        end
    end
endmodule
`default_nettype wire

@@ sv/fixed_point_alu.sv @@
// Pipeline: input registers, setup, one divider register stage per quotient bit, output register.
// Throughput: one item per cycle while the output is not stalled.
// Each stage holds its item under a stall and fills its bubbles from upstream.
// Reset (synchronous, active low) clears all valid bits; payload registers are not reset.
`default_nettype none
module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire fpa_pkg::t_op       i_opcode,
    input  wire logic signed [31:0] i_operand_a,
    input  wire logic signed [31:0] i_operand_b,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_result_raw,
    output logic                    o_compare_true,
    output logic                    o_error
);
    import fpa_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int NS = NW + 3;
    localparam int LAST = NS - 1;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_rdy;

    // Each stage may load when it is empty or its successor loads.
    always_comb begin
        w_rdy[LAST] = !r_v[LAST] || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_v[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 0: input registers.
    t_op                r_op;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_op <= i_opcode;
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
        end
    end

    // Stage 1: magnitudes, product, simple operations and divider setup.
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;
    logic signed [32:0] sum;
    logic               use_sum;
    t_side              n_side;

    always_comb begin
        mag_a   = r_a[31] ? 32'(-r_a) : r_a;
        mag_b   = r_b[31] ? 32'(-r_b) : r_b;
        sum     = '0;
        use_sum = 1'b0;
        n_side  = '0;
        n_side.op    = r_op;
        n_side.neg   = r_a[31] ^ r_b[31];
        n_side.bzero = (r_b == 32'sd0);
        n_side.prod  = 64'(mag_a) * 64'(mag_b);
        case (r_op)
            OP_ADD: begin
                sum = 33'(r_a) + 33'(r_b);
                use_sum = 1'b1;
            end
            OP_SUB: begin
                sum = 33'(r_a) - 33'(r_b);
                use_sum = 1'b1;
            end
            OP_INC: begin
                sum = 33'(r_a) + 33'sd1;
                use_sum = 1'b1;
            end
            OP_DEC: begin
                sum = 33'(r_a) - 33'sd1;
                use_sum = 1'b1;
            end
            OP_GT:  n_side.cmp = (r_a > r_b);
            OP_LT:  n_side.cmp = (r_a < r_b);
            OP_GE:  n_side.cmp = (r_a >= r_b);
            OP_LE:  n_side.cmp = (r_a <= r_b);
            OP_EQ:  n_side.cmp = (r_a == r_b);
            OP_NE:  n_side.cmp = (r_a != r_b);
            OP_MIN: n_side.res = (r_a < r_b) ? r_a : r_b;
            OP_MAX: n_side.res = (r_a > r_b) ? r_a : r_b;
            OP_INT: n_side.res = 32'(r_a >>> FRAC_BITS);
            default: begin
            end
        endcase
        // Saturate a 33-bit sum to the 32-bit range.
        if (use_sum) begin
            if (sum[32] != sum[31]) begin
                n_side.err = 1'b1;
                n_side.res = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                n_side.res = sum[31:0];
            end
        end
    end

    t_side         r_side [1:NW+1];
    logic [NW-1:0] r_num;
    logic [31:0]   r_den;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_side[1] <= n_side;
            r_num     <= NW'(mag_a) << FRAC_BITS;
            r_den     <= mag_b;
        end
        for (int k = 2; k <= NW + 1; k++) begin
            if (w_rdy[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Divider stages: one quotient bit each.
    logic [31:0]   w_rem [0:NW];
    logic [NW-1:0] w_num [0:NW];
    logic [31:0]   w_den [0:NW];
    logic [NW-1:0] w_quo [0:NW];

    assign w_rem[0] = '0;
    assign w_num[0] = r_num;
    assign w_den[0] = r_den;
    assign w_quo[0] = '0;

    for (genvar g = 0; g < NW; g++) begin : g_div
        fpa_div_stage #(
            .NW(NW)
        ) u_step (
            .i_clk (i_clk),
            .i_ld  (w_rdy[g+2]),
            .i_rem (w_rem[g]),
            .i_num (w_num[g]),
            .i_den (w_den[g]),
            .i_quo (w_quo[g]),
            .o_rem (w_rem[g+1]),
            .o_num (w_num[g+1]),
            .o_den (w_den[g+1]),
            .o_quo (w_quo[g+1])
        );
    end

    // Final stage: rounding half away from zero, saturation and the divide-by-zero error.
    t_side       s_in;
    logic [63:0] q;
    logic [63:0] half;
    logic        rnd;
    logic        neg_q;
    logic [31:0] n_res;
    logic        n_err;
    logic        n_cmp;

    always_comb begin
        s_in  = r_side[NW+1];
        half  = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
        rnd   = ({w_rem[NW], 1'b0} >= {1'b0, w_den[NW]});
        q     = '0;
        n_res = s_in.res;
        n_err = s_in.err;
        n_cmp = s_in.cmp;
        if (s_in.op == OP_MUL) begin
            q = (s_in.prod + half) >> FRAC_BITS;
        end else begin
            q = 64'(w_quo[NW]) + 64'(rnd);
        end
        neg_q = s_in.neg && (q != 64'd0);
        if (s_in.op == OP_MUL || (s_in.op == OP_DIV && !s_in.bzero)) begin
            if (neg_q) begin
                if (q > 64'h8000_0000) begin
                    n_err = 1'b1;
                    n_res = 32'h8000_0000;
                end else begin
                    n_res = 32'(-q);
                end
            end else begin
                if (q > 64'h7FFF_FFFF) begin
                    n_err = 1'b1;
                    n_res = 32'h7FFF_FFFF;
                end else begin
                    n_res = q[31:0];
                end
            end
        end else if (s_in.op == OP_DIV) begin
            n_err = 1'b1;
            n_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[LAST]) begin
            o_result_raw   <= n_res;
            o_compare_true <= n_cmp;
            o_error        <= n_err;
        end
    end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the fixed-point ALU with a scoreboard class and random traffic.
`default_nettype none
module tb_top;
    import fpa_pkg::*;

    localparam int FRAC_BITS = 8;
    localparam int LATENCY = FRAC_BITS + 35;

    // Opcode with no operation assigned; the block returns all zeros for it.
    localparam t_op OP_UNUSED = 4'd15;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_op i_opcode;
    logic signed [31:0] i_operand_a;
    logic signed [31:0] i_operand_b;
    logic o_valid;
    logic i_stall;
    logic signed [31:0] o_result_raw;
    logic o_compare_true;
    logic o_error;

    int mismatch_count = 0;
    bit hold_off = 0;
    bit sending_done = 0;

    typedef struct packed {
        logic [31:0] res;
        logic        cmp;
        logic        err;
    } t_alu_out;

    // Prints one line for a mismatch and counts it.
    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    // Saturates a sign and magnitude pair to 32 bits.
    function automatic logic [31:0] clamp_mag(input bit neg, input logic [63:0] mag,
                                              inout logic err);
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                err = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(64'd0 - mag);
        end
        if (mag > 64'h7FFF_FFFF) begin
            err = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    function automatic logic [31:0] clamp_s64(input logic signed [63:0] s, inout logic err);
        logic [63:0] mag;
        mag = (s < 0) ? 64'd0 - 64'(s) : 64'(s);
        return clamp_mag(s < 0, mag, err);
    endfunction

    // Computes the expected output for one operation.
    function automatic t_alu_out alu_predict(input t_op op, input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        t_alu_out r;
        logic signed [63:0] sa, sb;
        logic [63:0] ma, mb, p, q, n;
        logic [63:0] half;
        bit neg;
        r = '0;
        sa = a;
        sb = b;
        ma = (sa < 0) ? 64'd0 - 64'(sa) : 64'(sa);
        mb = (sb < 0) ? 64'd0 - 64'(sb) : 64'(sb);
        neg = (sa < 0) != (sb < 0);
        half = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
        case (op)
            OP_ADD: r.res = clamp_s64(sa + sb, r.err);
            OP_SUB: r.res = clamp_s64(sa - sb, r.err);
            OP_MUL: begin
                p = ma * mb;
                q = (p + half) >> FRAC_BITS;
                r.res = clamp_mag(neg && q != 0, q, r.err);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.err = 1'b1;
                end else begin
                    n = ma << FRAC_BITS;
                    q = (2 * n + mb) / (2 * mb);
                    r.res = clamp_mag(neg && q != 0, q, r.err);
                end
            end
            OP_GT: r.cmp = a > b;
            OP_LT: r.cmp = a < b;
            OP_GE: r.cmp = a >= b;
            OP_LE: r.cmp = a <= b;
            OP_EQ: r.cmp = a == b;
            OP_NE: r.cmp = a != b;
            OP_MIN: r.res = (a < b) ? a : b;
            OP_MAX: r.res = (a > b) ? a : b;
            OP_INC: r.res = clamp_s64(sa + 1, r.err);
            OP_DEC: r.res = clamp_s64(sa - 1, r.err);
            OP_INT: r.res = a >>> FRAC_BITS;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Holds the expected outputs in order of their input transfers.
    class alu_scoreboard;
        t_alu_out pending[$];

        function void note_input(t_op op, logic signed [31:0] a, logic signed [31:0] b);
            pending.push_back(alu_predict(op, a, b));
        endfunction

        task check_output(logic [31:0] res, logic cmp, logic err);
            t_alu_out e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", res));
                return;
            end
            e = pending.pop_front();
            if (res !== e.res)
                report($sformatf("result_raw got %h want %h", res, e.res));
            if (cmp !== e.cmp)
                report($sformatf("compare_true got %b want %b", cmp, e.cmp));
            if (err !== e.err)
                report($sformatf("error got %b want %b", err, e.err));
        endtask
    endclass

    alu_scoreboard sb = new();

    fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_valid(o_valid), .i_stall(i_stall), .o_result_raw(o_result_raw),
        .o_compare_true(o_compare_true), .o_error(o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offers one item and waits for its transfer; i_valid is dropped afterward unless keep_up is set.
    task automatic send_item(input t_op op, input logic [31:0] a, input logic [31:0] b,
                             input bit keep_up);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        sb.note_input(op, a, b);
        @(negedge i_clk);
        if (!keep_up) i_valid <= 1'b0;
    endtask

    task automatic send_gap(input int cycles);
        if (cycles == 0) return;
        i_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(0, 4)) - 32'd2;
            3: return 32'($signed($urandom_range(0, 2047)) - 1024);
            4: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_op pick_op();
        if ($urandom_range(0, 39) == 0) return OP_UNUSED;
        return t_op'($urandom_range(0, 14));
    endfunction

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // Stimulus process: directed corners, then random items with pauses.
    initial begin
        logic [31:0] corner_a[6];
        logic [31:0] corner_b[4];
        int gap;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_ADD;
        i_operand_a = '0;
        i_operand_b = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        corner_a = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h180, 32'hFFFF_FE80};
        corner_b = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h100};
        // Every operation on one corner pair each, plus the unused opcode.
        for (int op = 0; op < 16; op++)
            send_item(t_op'(op), corner_a[op % 6], corner_b[op % 4], 1'b1);
        send_item(OP_DIV, 32'h100, 32'h0, 1'b1);
        send_item(OP_INC, 32'h7FFF_FFFF, 32'h0, 1'b1);
        send_item(OP_DEC, 32'h8000_0000, 32'h0, 1'b1);
        send_item(OP_MIN, 32'h55, 32'h55, 1'b1);
        send_item(OP_MAX, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_item(OP_INT, 32'hFFFF_FF01, 32'h0, 1'b0);
        drain();

        for (int i = 0; i < 900; i++) begin
            // Receiver hold-off while the sender keeps offering back to back.
            if (i == 200) hold_off = 1'b1;
            // Sender pauses until everything has come out.
            if (i == 600) begin
                i_valid <= 1'b0;
                drain();
            end
            gap = (i % 200 < 50) ? 0 : $urandom_range(0, 6);
            send_gap(gap);
            send_item(pick_op(), pick_operand(), pick_operand(), 1'b1);
        end
        i_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver stall pattern, including one long hold-off.
    initial begin
        int w;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                hold_off = 1'b0;
                i_stall <= 1'b1;
                repeat (200) @(negedge i_clk);
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if ((($time / 3000) % 3) == 0) w = 0;
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
                while (!o_valid) @(posedge i_clk);
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_output(o_result_raw, o_compare_true, o_error);
    end

    // Final check after all results have arrived.
    initial begin
        wait (sending_done);
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        if (mismatch_count == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
sv/fpa_pkg.sv
sv/fpa_div_stage.sv
sv/fixed_point_alu.sv
tb/tb_top.sv
